FILE: rtl/double_ended_arena_allocator_top_defines.svh
// assertion macros for the arena allocator
`ifndef DOUBLE_ENDED_ARENA_ALLOCATOR_TOP_DEFINES_SVH
`define DOUBLE_ENDED_ARENA_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dea assertion failed");
// next-cycle implication
`define DEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dea assertion failed");
`else
`define DEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dea_pkg.sv
package dea_pkg;

  localparam int MARK_DEPTH = 16;
  localparam int MARK_AW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int MC_W       = $clog2(MARK_DEPTH + 1);

  localparam int MODE_W  = 4;
  localparam int SIZE_W  = 25;
  localparam int IDX_W   = 4;
  localparam int ADDR_W  = 32;
  localparam int MNUM_W  = 5;
  localparam int FREE_W  = 25;
  localparam int ROUND_W = SIZE_W + 1;
  localparam int AVAIL_W = ROUND_W + 1;

  // common width for mark count, index and stack address compares
  localparam int EXT_A = (IDX_W > MC_W) ? IDX_W : MC_W;
  localparam int EXT_B = (MNUM_W > MARK_AW) ? MNUM_W : MARK_AW;
  localparam int EXT_W = (EXT_A > EXT_B) ? EXT_A : EXT_B;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_BYTES = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_ALLOC_LO = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC_HI = 4'd1;
  localparam logic [MODE_W-1:0] MODE_REALLOC  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_POP      = 4'd4;
  localparam logic [MODE_W-1:0] MODE_POP_TO   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_CLR_LO   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_CLR_HI   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_REINIT   = 4'd8;

  localparam logic [ROUND_W-1:0] ROUND_ADD  = ROUND_W'(3);
  localparam logic [ROUND_W-1:0] ROUND_MASK = ROUND_W'(32'hffff_fffc);
  localparam logic [ADDR_W-1:0]  FREE_MAX   = {{(ADDR_W-FREE_W){1'b0}}, {FREE_W{1'b1}}};
  localparam logic [MC_W-1:0]    MARK_FULL  = MC_W'(MARK_DEPTH);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] alloc_size;
    logic [IDX_W-1:0]  mark_index;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [MNUM_W-1:0] mark_number;
    logic [FREE_W-1:0] free_bytes;
    logic              out_of_space;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               re;
    logic [MARK_AW-1:0] raddr;
    logic               we;
    logic [MARK_AW-1:0] waddr;
    logic [ADDR_W-1:0]  wdata;
  } mark_req_t;

endpackage

FILE: rtl/dea_mark_ram.sv
module dea_mark_ram
  import dea_pkg::*;
(
  input  logic              clk,
  input  mark_req_t         req,
  output logic [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem [MARK_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/dea_core.sv
module dea_core
  import dea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  in_item_t          in_item,
  input  cfg_wr_t           cfg_wr,
  input  logic [ADDR_W-1:0] mark_rd_data,
  output mark_req_t         mark_req,
  output out_item_t         result
);

  in_item_t          item_r;
  logic [ADDR_W-1:0] lp_r, lp_nxt;
  logic [ADDR_W-1:0] hp_r, hp_nxt;
  logic [ROUND_W-1:0] last_r, last_nxt;
  logic [MC_W-1:0]   mc_r, mc_nxt;
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] bytes_r;

  logic [ROUND_W-1:0] rounded;
  logic [FREE_W-1:0]  free_cur;
  logic [AVAIL_W-1:0] avail;
  logic               fits;
  logic               realloc_fits;
  logic               oos;
  logic               addr_set;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  arena_end;
  logic [ADDR_W-1:0]  rounded_ext;
  logic [ADDR_W-1:0]  last_ext;
  logic [EXT_W-1:0]   mc_ext;
  logic [EXT_W-1:0]   mc_dec_ext;
  logic [EXT_W-1:0]   in_idx_ext;
  logic [EXT_W-1:0]   idx_ext;
  logic [EXT_W-1:0]   mnum_ext;
  logic               pop_to_ok;

  function automatic logic [FREE_W-1:0] free_of(input logic [ADDR_W-1:0] hp,
                                                input logic [ADDR_W-1:0] lp);
    logic [ADDR_W-1:0] diff;
    diff = hp - lp;
    return (diff > FREE_MAX) ? '0 : diff[FREE_W-1:0];
  endfunction

  // stack read goes out at accept so the word is back for the execute cycle
  assign mc_ext     = EXT_W'(mc_r);
  assign mc_dec_ext = mc_ext - EXT_W'(1);
  assign in_idx_ext = EXT_W'(in_item.mark_index);
  assign idx_ext    = EXT_W'(item_r.mark_index);

  assign mark_req.re    = ctrl.accept;
  assign mark_req.raddr = (in_item.mode == MODE_POP_TO) ? in_idx_ext[MARK_AW-1:0]
                                                         : mc_dec_ext[MARK_AW-1:0];
  assign mark_req.we    = ctrl.exec && (item_r.mode == MODE_PUSH) && (mc_r != MARK_FULL);
  assign mark_req.waddr = mc_ext[MARK_AW-1:0];
  assign mark_req.wdata = lp_r;

  assign rounded      = (ROUND_W'(item_r.alloc_size) + ROUND_ADD) & ROUND_MASK;
  assign rounded_ext  = ADDR_W'(rounded);
  assign last_ext     = ADDR_W'(last_r);
  assign free_cur     = free_of(hp_r, lp_r);
  assign avail        = AVAIL_W'(free_cur) + AVAIL_W'(last_r);
  assign fits         = rounded <= ROUND_W'(free_cur);
  assign realloc_fits = AVAIL_W'(rounded) <= avail;
  assign arena_end    = base_r + ADDR_W'(bytes_r);
  assign pop_to_ok    = (idx_ext < mc_ext) && (idx_ext < EXT_W'(MARK_DEPTH));

  always_comb begin
    lp_nxt   = lp_r;
    hp_nxt   = hp_r;
    last_nxt = last_r;
    mc_nxt   = mc_r;
    oos      = 1'b0;
    addr_set = 1'b0;
    addr     = '0;
    unique case (item_r.mode)
      MODE_ALLOC_LO: begin
        addr_set = 1'b1;
        if (!fits) begin
          oos = 1'b1;
        end else begin
          addr     = lp_r;
          lp_nxt   = lp_r + rounded_ext;
          last_nxt = rounded;
        end
      end
      MODE_ALLOC_HI: begin
        addr_set = 1'b1;
        if (!fits) begin
          oos = 1'b1;
        end else begin
          hp_nxt   = hp_r - rounded_ext;
          last_nxt = rounded;
          addr     = hp_r - rounded_ext;
        end
      end
      MODE_REALLOC: begin
        addr_set = 1'b1;
        if (!realloc_fits) begin
          oos = 1'b1;
        end else begin
          lp_nxt   = lp_r - last_ext + rounded_ext;
          last_nxt = rounded;
          addr     = lp_r - last_ext + rounded_ext;
        end
      end
      MODE_PUSH: begin
        if (mc_r != MARK_FULL) begin
          mc_nxt = mc_r + MC_W'(1);
        end
      end
      MODE_POP: begin
        if (mc_r != '0) begin
          mc_nxt = mc_dec_ext[MC_W-1:0];
          lp_nxt = mark_rd_data;
        end
      end
      MODE_POP_TO: begin
        if (pop_to_ok) begin
          mc_nxt = idx_ext[MC_W-1:0];
          lp_nxt = mark_rd_data;
        end
      end
      MODE_CLR_LO: begin
        mc_nxt = '0;
        lp_nxt = base_r;
      end
      MODE_CLR_HI: begin
        hp_nxt = arena_end;
      end
      MODE_REINIT: begin
        lp_nxt = base_r;
        hp_nxt = arena_end;
        mc_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // push reports the count it saw, everything else the count it leaves
  assign mnum_ext = (item_r.mode == MODE_PUSH) ? mc_ext : EXT_W'(mc_nxt);

  assign result.address      = oos ? '0 : (addr_set ? addr : lp_nxt);
  assign result.mark_number  = mnum_ext[MNUM_W-1:0];
  assign result.free_bytes   = free_of(hp_nxt, lp_nxt);
  assign result.out_of_space = oos;

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r    <= '0;
      hp_r    <= '0;
      last_r  <= '0;
      mc_r    <= '0;
      base_r  <= '0;
      bytes_r <= '0;
    end else begin
      if (ctrl.exec) begin
        lp_r   <= lp_nxt;
        hp_r   <= hp_nxt;
        last_r <= last_nxt;
        mc_r   <= mc_nxt;
      end
      if (cfg_wr.we && (cfg_wr.index == REG_ARENA_BASE)) begin
        base_r <= cfg_wr.data;
      end
      if (cfg_wr.we && (cfg_wr.index == REG_ARENA_BYTES)) begin
        bytes_r <= cfg_wr.data[SIZE_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/double_ended_arena_allocator_top.sv
// channel | direction | handshake           | word
// in      | input     | in_valid/in_stall   | in_data (mode, alloc_size, mark_index)
// out     | output    | out_valid/out_stall | out_data (address, mark_number, free_bytes, oos)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word at a time: accept issues the mark stack read, the next cycle
// executes with the registered read data and loads the output register
// a new word is taken while the previous result is being taken or already gone
// reset is synchronous and clears pointers, counts, arena config and state; the mark stack
// is not cleared and needs no clearing pass
// out_stall holds the result and, once a result waits, holds off in_data
`include "double_ended_arena_allocator_top_defines.svh"

module double_ended_arena_allocator_top
  import dea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t result;
  ctrl_t     ctrl;
  cfg_wr_t   cfg_wr;
  mark_req_t mark_req;
  logic [ADDR_W-1:0] mark_rd_data;
  logic      out_free;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE) || !out_free;
  assign ctrl.accept = in_valid && !in_stall;
  assign ctrl.exec   = (state_r == S_EXEC);

  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctrl.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (ctrl.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dea_mark_ram u_mark_ram (
    .clk     (clk),
    .req     (mark_req),
    .rd_data (mark_rd_data)
  );

  dea_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_item      (in_data),
    .cfg_wr       (cfg_wr),
    .mark_rd_data (mark_rd_data),
    .mark_req     (mark_req),
    .result       (result)
  );

  // an accepted word always executes next cycle
  `DEA_ASSERT_NEXT(a_accept_exec, clk, rst_n, ctrl.accept, state_r == S_EXEC)
  // execute always lands a result
  `DEA_ASSERT_NEXT(a_exec_result, clk, rst_n, ctrl.exec, out_valid_r)
  // output register is empty whenever a result is produced
  `DEA_ASSERT_IMPL(a_exec_out_free, clk, rst_n, ctrl.exec, !out_valid_r)

endmodule
